/* design/ehlp_pkg.sv */
// Package for the etag header line parser.
// Holds the parser phase and status codes, the key constants and the result record.
// No dependencies.
package ehlp_pkg;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_KEY    = 3'd0,
    PH_PRE    = 3'd1,
    PH_POST   = 3'd2,
    PH_VALUE  = 3'd3,
    PH_IGNORE = 3'd4
  } phase_t;

  // Line status codes as reported on the final byte.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_ETAG   = 2'd1,
    ST_BAD_FORMAT = 2'd2,
    ST_TOO_LONG   = 2'd3
  } status_t;

  // Key letters, lowest position in the lowest byte.
  localparam logic [3:0][7:0] KEY_LO = {8'h67, 8'h61, 8'h74, 8'h65};
  localparam logic [3:0][7:0] KEY_UP = {8'h47, 8'h41, 8'h54, 8'h45};

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  // Width of the index and length fields on the result channel.
  localparam int OUT_CNT_W = 6;

  // Control state of the parser, apart from the value count.
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  key_pos;
    status_t     err;
  } ctrl_t;

  // One result record; value_byte sits in the lowest bits.
  typedef struct packed {
    logic [OUT_CNT_W-1:0] value_length;
    status_t              status;
    logic                 finished;
    logic [OUT_CNT_W-1:0] value_index;
    logic                 value_valid;
    logic [7:0]           value_byte;
  } res_t;

  // A space or a horizontal tab.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

endpackage

/* design/ehlp_step.sv */
// Next-state and result logic of the etag header line parser for one byte.
// Depends on ehlp_pkg.
module ehlp_step
  import ehlp_pkg::*;
#(
  parameter int VALUE_BUFFER_BYTES = 64,
  parameter int CNT_W              = 6
) (
  input  ctrl_t            ctrl,
  input  logic [CNT_W-1:0] count,
  input  logic [7:0]       hdr_byte,
  input  logic             line_end,
  output ctrl_t            ctrl_nxt,
  output logic [CNT_W-1:0] count_nxt,
  output res_t             res
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(VALUE_BUFFER_BYTES - 1);

  ctrl_t            c_upd;
  logic [CNT_W-1:0] n_upd;
  logic             vvalid;
  logic [CNT_W-1:0] vindex;

  // Per-phase update of the parser for this byte.
  always_comb begin
    c_upd  = ctrl;
    n_upd  = count;
    vvalid = 1'b0;
    vindex = '0;
    unique case (ctrl.phase)
      PH_KEY: begin
        if (hdr_byte == KEY_LO[ctrl.key_pos] || hdr_byte == KEY_UP[ctrl.key_pos]) begin
          if (ctrl.key_pos == 2'd3) begin
            c_upd.phase = PH_PRE;
          end else begin
            c_upd.key_pos = ctrl.key_pos + 2'd1;
          end
        end else begin
          c_upd.err   = ST_NOT_ETAG;
          c_upd.phase = PH_IGNORE;
        end
      end
      PH_PRE: begin
        if (is_blank(hdr_byte)) begin
          c_upd.phase = PH_PRE;
        end else if (hdr_byte == CHAR_COLON) begin
          c_upd.phase = PH_POST;
        end else begin
          c_upd.err   = ST_BAD_FORMAT;
          c_upd.phase = PH_IGNORE;
        end
      end
      PH_POST: begin
        // Any byte other than a blank opens the value.
        if (!is_blank(hdr_byte)) begin
          c_upd.phase = PH_VALUE;
          vvalid      = 1'b1;
          n_upd       = CNT_W'(1);
        end
      end
      PH_VALUE: begin
        if (is_blank(hdr_byte) || hdr_byte == CHAR_CR) begin
          c_upd.phase = PH_IGNORE;
        end else if (count < CNT_MAX) begin
          vvalid = 1'b1;
          vindex = count;
          n_upd  = count + CNT_W'(1);
        end else begin
          c_upd.err   = ST_TOO_LONG;
          c_upd.phase = PH_IGNORE;
        end
      end
      default: begin
        c_upd = ctrl;
      end
    endcase
  end

  // Result record and return to the idle state on the final byte.
  always_comb begin
    res.value_byte  = vvalid ? hdr_byte : 8'h00;
    res.value_valid = vvalid;
    res.value_index = OUT_CNT_W'(vindex);
    res.finished    = line_end;
    res.status      = line_end ? c_upd.err : ST_OK;
    res.value_length = (line_end && c_upd.err == ST_OK) ? OUT_CNT_W'(n_upd) : '0;
    if (line_end) begin
      ctrl_nxt.phase   = PH_KEY;
      ctrl_nxt.key_pos = 2'd0;
      ctrl_nxt.err     = ST_OK;
      count_nxt        = '0;
    end else begin
      ctrl_nxt  = c_upd;
      count_nxt = n_upd;
    end
  end

endmodule

/* design/ehlp_out_buf.sv */
// Two-entry output buffer that separates the result channel from the input side.
// Depends on ehlp_pkg for the result record.
module ehlp_out_buf
  import ehlp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  res_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output res_t pop_data
);

  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_FULL  = 2'd2;

  logic [1:0] fill_r, fill_nxt;
  res_t       head_r, head_nxt;
  res_t       tail_r, tail_nxt;
  logic       push, pop;

  assign push_ready = (fill_r != FILL_FULL);
  assign pop_valid  = (fill_r != FILL_EMPTY);
  assign pop_data   = head_r;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Slot and fill update.
  always_comb begin
    fill_nxt = fill_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    unique case (fill_r)
      FILL_EMPTY: begin
        if (push) begin
          head_nxt = push_data;
          fill_nxt = FILL_ONE;
        end
      end
      FILL_ONE: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          tail_nxt = push_data;
          fill_nxt = FILL_FULL;
        end else if (pop) begin
          fill_nxt = FILL_EMPTY;
        end
      end
      FILL_FULL: begin
        if (pop) begin
          head_nxt = tail_r;
          fill_nxt = FILL_ONE;
        end
      end
      default: begin
        fill_nxt = FILL_EMPTY;
      end
    endcase
  end

  // Fill count is reset; the slots hold payload only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= FILL_EMPTY;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

/* design/etag_header_line_parser.sv */
// Top level of the etag header line parser: parser state registers and output buffer.
// Depends on ehlp_pkg, ehlp_step and ehlp_out_buf.
//
// Channel  Direction  Signals                        Content
// in_      slave      tvalid tready tdata[7:0] tlast  header byte, tlast on final byte
// out_     master     tvalid tready tdata[23:0] tlast one result per byte, tlast = finished
//
// A new byte is accepted every cycle while the two-entry output buffer has room;
// its result is registered in the output buffer, and results leave in byte order.
// Reset is synchronous and active low; it returns the parser to key matching
// and empties the output buffer.
// A stall on out_tready fills the buffer, and in_tready drops once it holds two results.
module etag_header_line_parser
  import ehlp_pkg::*;
#(
  parameter int VALUE_BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] header_byte
  input  logic        in_tlast,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] value_byte, [8] value_valid, [14:9] value_index,
                                  // [16:15] status, [22:17] value_length, [23] zero
  output logic        out_tlast   // finished
);

  localparam int CNT_W = $clog2(VALUE_BUFFER_BYTES);

  ctrl_t            ctrl_r, ctrl_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  res_t             step_res;
  res_t             out_res;
  logic             in_accept;

  assign in_accept = in_tvalid && in_tready;

  // Byte-level parser logic.
  ehlp_step #(
    .VALUE_BUFFER_BYTES (VALUE_BUFFER_BYTES),
    .CNT_W              (CNT_W)
  ) u_step (
    .ctrl      (ctrl_r),
    .count     (count_r),
    .hdr_byte  (in_tdata),
    .line_end  (in_tlast),
    .ctrl_nxt  (ctrl_nxt),
    .count_nxt (count_nxt),
    .res       (step_res)
  );

  // Parser state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.phase   <= PH_KEY;
      ctrl_r.key_pos <= 2'd0;
      ctrl_r.err     <= ST_OK;
      count_r        <= '0;
    end else if (in_accept) begin
      ctrl_r  <= ctrl_nxt;
      count_r <= count_nxt;
    end
  end

  // Result buffering toward the output channel.
  ehlp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (step_res),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (out_res)
  );

  assign out_tdata = {1'b0, out_res.value_length, out_res.status, out_res.value_index,
                      out_res.value_valid, out_res.value_byte};
  assign out_tlast = out_res.finished;

  // A final byte returns the parser to its idle state.
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tlast) |=>
      (ctrl_r.phase == PH_KEY && ctrl_r.key_pos == 2'd0 && ctrl_r.err == ST_OK
       && count_r == '0))
    else $error("parser state not cleared after final byte");

  // A latched error always sends the parser to the ignore phase.
  a_err_ignores: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r.err != ST_OK) |-> (ctrl_r.phase == PH_IGNORE))
    else $error("error latched outside the ignore phase");

  // No value byte is counted while the key or the separator is being matched.
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r.phase == PH_KEY || ctrl_r.phase == PH_PRE || ctrl_r.phase == PH_POST)
      |-> (count_r == '0))
    else $error("value count nonzero before the value starts");

endmodule
